[rtl/tla_pkg.sv]
// Shared types and constants for the tour length accumulator.
`default_nettype none

package tla_pkg;

    // Entries in the queue between the front and the back end
    localparam int QUEUE_DEPTH = 2;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_LOAD,
        ST_ROOT,
        ST_ACC,
        ST_EMIT
    } tla_state_t;

    // Work class attached to each queued city
    typedef struct packed {
        logic has_dist;   // a previous city exists: add a leg
        logic last;       // closes the tour: emit the total
    } tla_ctl_t;

endpackage

`default_nettype wire

[rtl/tla_front.sv]
// Front end: takes city beats, forms the leg deltas and classifies the work.
`default_nettype none

module tla_front
    import tla_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int IN_W       = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,
    input  wire logic                  s_tlast,
    output logic                       push,
    output logic [COORD_BITS-1:0]      push_dx,
    output logic [COORD_BITS-1:0]      push_dy,
    output tla_ctl_t                   push_ctl,
    input  wire logic                  q_full
);

    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic                  have_prev_reg, have_prev_next;
    logic [COORD_BITS-1:0] city_x;
    logic [COORD_BITS-1:0] city_y;
    logic                  accept;

    assign city_x   = s_tdata[COORD_BITS-1:0];
    assign city_y   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Absolute deltas against the previous city
    assign push_dx = (city_x >= prev_x_reg) ? city_x - prev_x_reg : prev_x_reg - city_x;
    assign push_dy = (city_y >= prev_y_reg) ? city_y - prev_y_reg : prev_y_reg - city_y;

    // Drop a first city that does not close the tour: it carries no work
    assign push_ctl.has_dist = have_prev_reg;
    assign push_ctl.last     = s_tlast;
    assign push              = accept && (have_prev_reg || s_tlast);

    // Track the previous city; a last beat starts a new tour
    always_comb begin
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (accept) begin
            prev_x_next    = city_x;
            prev_y_next    = city_y;
            have_prev_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end else begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tla_fifo.sv]
// Short queue that decouples the front end from the back end.
`default_nettype none

module tla_fifo
    import tla_pkg::*;
#(
    parameter int W = 22
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire logic [W-1:0]  wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output logic [W-1:0]       rd_data,
    output logic               empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap and track occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tla_back.sv]
// Back end: squares the deltas, takes the bit-serial root, accumulates and emits.
`default_nettype none

module tla_back
    import tla_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8,
    parameter int COST_BITS  = 34,
    parameter int OUT_W      = 40
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    input  wire logic [COORD_BITS-1:0] q_dx,
    input  wire logic [COORD_BITS-1:0] q_dy,
    input  wire tla_ctl_t              q_ctl,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tuser
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int RAD_W  = 2 * COORD_BITS + 2;
    localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int SUM_W  = ((COST_BITS > ROOT_W) ? COST_BITS : ROOT_W) + 1;
    localparam int CNT_W  = $clog2(ROOT_W + 1);
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    tla_state_t             state_reg, state_next;
    logic [COORD_BITS-1:0]  dx_reg, dx_next;
    logic [COORD_BITS-1:0]  dy_reg, dy_next;
    tla_ctl_t               ctl_reg, ctl_next;
    logic [SQ_W-1:0]        sqx_reg, sqx_next;
    logic [SQ_W-1:0]        sqy_reg, sqy_next;
    logic [RAD_W-1:0]       rad_reg, rad_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COST_BITS-1:0]   run_reg, run_next;
    logic                   ovf_reg, ovf_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COST_BITS-1:0]   m_cost_reg, m_cost_next;
    logic                   m_sat_reg, m_sat_next;

    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic                   take_bit;
    logic [SUM_W-1:0]       sum_full;
    logic                   sum_over;

    // One root digit per cycle: bring down the next radicand pair, try 4*root+1
    assign rem_sh   = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign take_bit = (rem_sh >= trial);

    // Running total plus this leg, clamped at the top of the cost range
    assign sum_full = SUM_W'(run_reg) + SUM_W'(root_reg);
    assign sum_over = (sum_full > SUM_W'(COST_MAX));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_cost_reg);
    assign m_tuser  = m_sat_reg;

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next   = state_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        ctl_next     = ctl_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        run_next     = run_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_cost_next  = m_cost_reg;
        m_sat_next   = m_sat_reg;
        q_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    dx_next    = q_dx;
                    dy_next    = q_dy;
                    ctl_next   = q_ctl;
                    state_next = q_ctl.has_dist ? ST_SQUARE : ST_EMIT;
                end
            end
            ST_SQUARE: begin
                sqx_next   = SQ_W'(dx_reg) * SQ_W'(dx_reg);
                sqy_next   = SQ_W'(dy_reg) * SQ_W'(dy_reg);
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                rad_next   = RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                rem_next  = take_bit ? rem_sh - trial : rem_sh;
                root_next = {root_reg[ROOT_W-2:0], take_bit};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                run_next   = sum_over ? COST_MAX : sum_full[COST_BITS-1:0];
                ovf_next   = ovf_reg || sum_over;
                state_next = ctl_reg.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // Hold until the output register is free or being drained
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_cost_next  = run_reg;
                    m_sat_next   = ovf_reg;
                    run_next     = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        ctl_reg    <= ctl_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        cnt_reg    <= cnt_next;
        m_cost_reg <= m_cost_next;
        m_sat_reg  <= m_sat_next;
    end

endmodule

`default_nettype wire

[rtl/tour_length_accumulator_top.sv]
// Top level of the tour length accumulator: front end, queue and back end.
//
// Cities of an open tour arrive on the s_ channel, one per beat, as x and y
// grid coordinates in visiting order; s_tlast marks the final city. Each
// city after the first adds floor(sqrt(dx^2 + dy^2) * 2^FRAC_BITS) to a
// running total. On the last city one result beat leaves on the m_ channel:
// the total in m_tdata (FRAC_BITS fraction bits, clamped at 2^COST_BITS-1)
// and the clamp flag in m_tuser. A one-city tour gives a total of zero.
// The front end takes a beat whenever the queue is not full and queues up to
// two legs. The back end works on one leg at a time: one dequeue, one square,
// one load, one root digit per cycle of the digit-serial square root, one
// accumulate. It takes the next leg from the queue only once it is back in
// idle. A last city then passes through an emit step that loads the output
// register with the total.
// Reset clears the queue, the previous city and the total; s_tready is high
// on the cycle after reset. When the receiver stalls, the result holds in
// the output register, the back end waits on the next result and the queue
// fills, after which s_tready falls.
`default_nettype none

module tour_length_accumulator_top
    import tla_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8,
    parameter int COST_BITS  = 34
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // city_x, city_y, zero fill
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // tour_cost, zero fill
    output logic [((COST_BITS+7)/8)*8-1:0]            m_tdata,
    // cost_saturated
    output logic                                      m_tuser
);

    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((COST_BITS + 7) / 8) * 8;
    localparam int Q_W   = 2 * COORD_BITS + $bits(tla_ctl_t);

    logic                  push;
    logic [COORD_BITS-1:0] push_dx;
    logic [COORD_BITS-1:0] push_dy;
    tla_ctl_t              push_ctl;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic [Q_W-1:0]        q_rd_data;
    logic [COORD_BITS-1:0] q_dx;
    logic [COORD_BITS-1:0] q_dy;
    tla_ctl_t              q_ctl;

    tla_front #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (push),
        .push_dx  (push_dx),
        .push_dy  (push_dy),
        .push_ctl (push_ctl),
        .q_full   (q_full)
    );

    tla_fifo #(
        .W (Q_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data ({push_dx, push_dy, push_ctl}),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign {q_dx, q_dy, q_ctl} = q_rd_data;

    tla_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .COST_BITS  (COST_BITS),
        .OUT_W      (OUT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_dx     (q_dx),
        .q_dy     (q_dy),
        .q_ctl    (q_ctl),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A clamped total must read as the full-scale cost
    a_sat_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (&m_tdata[COST_BITS-1:0]))
        else $error("clamped total is not full scale");

    // The queue comes out of reset empty, so the input side is open
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // Nothing reaches the back end without having been queued
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

endmodule

`default_nettype wire
